// File: rtl/core/modular_exponentiation_top_macros.svh
// assertion macros for the modular exponentiation checker
// expects clk and rst_n in the scope where a macro is used
`ifndef MODULAR_EXPONENTIATION_TOP_MACROS_SVH
`define MODULAR_EXPONENTIATION_TOP_MACROS_SVH

// property must hold at every clock edge outside reset
`define MEXP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define MEXP_NEVER(name, expr, msg) \
  `MEXP_ASSERT(name, !(expr), msg)

`endif

// File: rtl/core/mexp_pkg.sv
// shared types and field widths of the modular exponentiation block
// no dependencies
package mexp_pkg;

  localparam int BASE_W = 63;
  localparam int EXP_W  = 32;
  localparam int MOD_W  = 31;

  // base reduction step counter, counts BASE_W-1 down to 0
  localparam int RED_CW = $clog2(BASE_W);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RED  = 3'b010,
    ST_MUL  = 3'b100
  } mexp_state_t;

endpackage

// File: rtl/core/mexp_mulmod.sv
// bit-serial modular multiplier, one multiplier bit per cycle, msb first
// standalone, operands b and m must stay stable while a product is running
module mexp_mulmod #(
  parameter int W = 31
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         go,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] m,
  output logic         done,
  output logic [W-1:0] p
);

  localparam int CW = $clog2(W + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  a_r, a_nxt;
  logic [W-1:0]  r_r, r_nxt;

  logic [W+1:0]  sum;
  logic [W+1:0]  m1;
  logic [W+1:0]  m2;
  logic [W+1:0]  red;

  // 2r + bit*b stays below 3m, so at most two subtractions of m
  always_comb begin
    m1  = {2'b00, m};
    m2  = {1'b0, m, 1'b0};
    sum = {1'b0, r_r, 1'b0} + {2'b00, (a_r[W-1] ? b : '0)};
    if (sum >= m2) begin
      red = sum - m2;
    end else if (sum >= m1) begin
      red = sum - m1;
    end else begin
      red = sum;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    r_nxt    = r_r;
    if (go) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(W);
      a_nxt    = a;
      r_nxt    = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r - CW'(1);
      a_nxt   = a_r << 1;
      r_nxt   = red[W-1:0];
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    a_r   <= a_nxt;
    r_r   <= r_nxt;
  end

  assign done = done_r;
  assign p    = r_r;

endmodule

// File: rtl/core/modular_exponentiation_top.sv
// modular exponentiation, right-to-left square and multiply
// uses mexp_pkg and two mexp_mulmod bit-serial multipliers
// a zero modulus gives a zero result; else the base is reduced, then one square and multiply
//   runs per exponent bit up to the highest set bit, and the result strobe follows the last
// throughput: one word at a time, the next word is taken in the result strobe cycle
// synchronous active-low reset returns to idle; the receiver cannot stall
module modular_exponentiation_top #(
  parameter int MOD_BITS = 31,
  parameter int EXP_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [mexp_pkg::BASE_W-1:0]  in_base,
  input  logic [mexp_pkg::EXP_W-1:0]   in_exponent,
  input  logic [mexp_pkg::MOD_W-1:0]   in_modulus,
  output logic                         out_valid,
  output logic [mexp_pkg::MOD_W-1:0]   out_power_mod
);

  localparam int EU = (EXP_BITS < mexp_pkg::EXP_W) ? EXP_BITS : mexp_pkg::EXP_W;
  localparam int OW = mexp_pkg::MOD_W;
  localparam int RW = mexp_pkg::RED_CW;

  mexp_pkg::mexp_state_t state_r, state_nxt;

  logic [mexp_pkg::BASE_W-1:0] base_r, base_nxt;
  logic [EU-1:0]               exp_r, exp_nxt;
  logic [MOD_BITS-1:0]         mod_r, mod_nxt;
  logic [MOD_BITS-1:0]         b_r, b_nxt;
  logic [MOD_BITS-1:0]         acc_r, acc_nxt;
  logic [RW-1:0]               cnt_r, cnt_nxt;
  logic                        go_r, go_nxt;
  logic                        ov_r, ov_nxt;
  logic [OW-1:0]               res_r, res_nxt;

  logic [MOD_BITS-1:0]         mod_in;
  logic [MOD_BITS:0]           rem_sh;
  logic [MOD_BITS:0]           rem_sub;
  logic [MOD_BITS-1:0]         rem_new;
  logic [MOD_BITS-1:0]         acc_init;
  logic [MOD_BITS-1:0]         acc_upd;
  logic [EU-1:0]               exp_sh;
  logic                        sq_done;
  logic                        pr_done;
  logic [MOD_BITS-1:0]         sq_p;
  logic [MOD_BITS-1:0]         pr_p;

  assign mod_in = in_modulus[MOD_BITS-1:0];

  // restoring remainder step, one base bit per cycle
  always_comb begin
    rem_sh  = {b_r, base_r[mexp_pkg::BASE_W-1]};
    rem_sub = rem_sh - {1'b0, mod_r};
    rem_new = (rem_sh >= {1'b0, mod_r}) ? rem_sub[MOD_BITS-1:0] : rem_sh[MOD_BITS-1:0];
  end

  assign acc_init = (mod_r == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
  assign acc_upd  = exp_r[0] ? pr_p : acc_r;
  assign exp_sh   = exp_r >> 1;

  always_comb begin
    state_nxt = state_r;
    base_nxt  = base_r;
    exp_nxt   = exp_r;
    mod_nxt   = mod_r;
    b_nxt     = b_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    go_nxt    = 1'b0;
    ov_nxt    = 1'b0;
    res_nxt   = res_r;
    unique case (state_r)
      mexp_pkg::ST_IDLE: begin
        if (start) begin
          base_nxt = in_base;
          exp_nxt  = in_exponent[EU-1:0];
          mod_nxt  = mod_in;
          b_nxt    = '0;
          cnt_nxt  = RW'(mexp_pkg::BASE_W - 1);
          if (mod_in == '0) begin
            // no reduction possible, result is zero
            ov_nxt  = 1'b1;
            res_nxt = '0;
          end else begin
            state_nxt = mexp_pkg::ST_RED;
          end
        end
      end
      mexp_pkg::ST_RED: begin
        b_nxt    = rem_new;
        base_nxt = base_r << 1;
        cnt_nxt  = cnt_r - RW'(1);
        if (cnt_r == '0) begin
          acc_nxt = acc_init;
          if (exp_r == '0) begin
            ov_nxt    = 1'b1;
            res_nxt   = OW'(acc_init);
            state_nxt = mexp_pkg::ST_IDLE;
          end else begin
            go_nxt    = 1'b1;
            state_nxt = mexp_pkg::ST_MUL;
          end
        end
      end
      mexp_pkg::ST_MUL: begin
        if (sq_done) begin
          b_nxt   = sq_p;
          acc_nxt = acc_upd;
          exp_nxt = exp_sh;
          // stop once no set exponent bits remain
          if (exp_sh == '0) begin
            ov_nxt    = 1'b1;
            res_nxt   = OW'(acc_upd);
            state_nxt = mexp_pkg::ST_IDLE;
          end else begin
            go_nxt = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = mexp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mexp_pkg::ST_IDLE;
      go_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go_r    <= go_nxt;
      ov_r    <= ov_nxt;
    end
    base_r <= base_nxt;
    exp_r  <= exp_nxt;
    mod_r  <= mod_nxt;
    b_r    <= b_nxt;
    acc_r  <= acc_nxt;
    cnt_r  <= cnt_nxt;
    res_r  <= res_nxt;
  end

  // square and conditional product run in lock step
  mexp_mulmod #(.W(MOD_BITS)) u_sq (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go_r),
    .a     (b_r),
    .b     (b_r),
    .m     (mod_r),
    .done  (sq_done),
    .p     (sq_p)
  );

  mexp_mulmod #(.W(MOD_BITS)) u_pr (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go_r),
    .a     (acc_r),
    .b     (b_r),
    .m     (mod_r),
    .done  (pr_done),
    .p     (pr_p)
  );

  assign busy          = (state_r != mexp_pkg::ST_IDLE) || (pr_done && !sq_done);
  assign out_valid     = ov_r;
  assign out_power_mod = res_r;

endmodule

// File: rtl/core/mexp_chk.sv
// port-level checker for modular_exponentiation_top, bound below
// uses mexp_pkg and modular_exponentiation_top_macros.svh
`include "modular_exponentiation_top_macros.svh"

module mexp_chk #(
  parameter int MOD_BITS = 31
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic [mexp_pkg::MOD_W-1:0] in_modulus,
  input logic                       out_valid,
  input logic [mexp_pkg::MOD_W-1:0] out_power_mod
);

  localparam int OW = mexp_pkg::MOD_W;

  logic [OW-1:0] mask;
  logic [OW-1:0] cap_r, cap_nxt;

  // modulus of the word in flight, as the block sees it
  assign mask    = (OW'(1) << MOD_BITS) - OW'(1);
  assign cap_nxt = (start && !busy) ? (in_modulus & mask) : cap_r;

  always_ff @(posedge clk) begin
    cap_r <= cap_nxt;
  end

  `MEXP_ASSERT(a_accept_leads_on, start && !busy |=> busy || out_valid, "accepted word lost")
  `MEXP_NEVER(a_strobe_while_busy, out_valid && busy, "result strobe while busy")
  `MEXP_ASSERT(a_finish_strobes, $fell(busy) |-> out_valid, "busy fell without a result")
  `MEXP_ASSERT(a_result_reduced, out_valid && cap_r != '0 |-> out_power_mod < cap_r, "result not reduced")
  `MEXP_ASSERT(a_zero_mod_zero, out_valid && cap_r == '0 |-> out_power_mod == '0, "zero modulus gave nonzero result")

endmodule

bind modular_exponentiation_top mexp_chk #(.MOD_BITS(MOD_BITS)) u_mexp_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_modulus    (in_modulus),
  .out_valid     (out_valid),
  .out_power_mod (out_power_mod)
);

// File: sim/modular_exponentiation_top_test.sv
// self-checking testbench for modular_exponentiation_top
// depends on mexp_pkg and the modular_exponentiation_top rtl, nothing else
// directed corner words first, then random words, all checked against a square-and-multiply predictor
module modular_exponentiation_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BASE_W = mexp_pkg::BASE_W;
  localparam int EXP_W  = mexp_pkg::EXP_W;
  localparam int MOD_W  = mexp_pkg::MOD_W;

  typedef struct {
    logic [BASE_W-1:0] base;
    logic [EXP_W-1:0]  exponent;
    logic [MOD_W-1:0]  modulus;
    int unsigned       gap;
    bit                drain;
  } exp_job_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [BASE_W-1:0] in_base = '0;
  logic [EXP_W-1:0]  in_exponent = '0;
  logic [MOD_W-1:0]  in_modulus = '0;
  logic              out_valid;
  logic [MOD_W-1:0]  out_power_mod;

  exp_job_t         job_q[$];
  logic [MOD_W-1:0] power_q[$];
  int unsigned      total_jobs = 0;
  int unsigned      accepted_count = 0;
  int unsigned      error_count = 0;
  int unsigned      gap_left = 0;
  bit               gap_loaded = 1'b0;

  modular_exponentiation_top uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_base      (in_base),
    .in_exponent  (in_exponent),
    .in_modulus   (in_modulus),
    .out_valid    (out_valid),
    .out_power_mod(out_power_mod)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // right-to-left square and multiply; reduced operands stay below 2^31 so products fit
  function automatic logic [MOD_W-1:0] power_mod_of(logic [BASE_W-1:0] b,
                                                    logic [EXP_W-1:0] e,
                                                    logic [MOD_W-1:0] m);
    longint unsigned acc;
    longint unsigned sq;
    longint unsigned mm;
    if (m == '0) begin
      return '0;
    end
    mm = 64'(m);
    sq = 64'(b) % mm;
    acc = 64'(1) % mm;
    for (int i = 0; i < EXP_W; i++) begin
      if (e[i]) begin
        acc = (acc * sq) % mm;
      end
      sq = (sq * sq) % mm;
    end
    return acc[MOD_W-1:0];
  endfunction

  task automatic add_job(logic [BASE_W-1:0] b, logic [EXP_W-1:0] e, logic [MOD_W-1:0] m,
                         int unsigned gap, bit drain);
    exp_job_t j;
    j.base = b;
    j.exponent = e;
    j.modulus = m;
    j.gap = gap;
    j.drain = drain;
    job_q = {job_q, j};
    total_jobs++;
  endtask

  task automatic report_mismatch(string what);
    $display("ERROR at %0t: %s", $time, what);
    error_count++;
  endtask

  // driver: start stays up until the word is taken, then the next word's gap runs
  always @(posedge clk) begin : driver
    bit send;
    send = 1'b0;
    if (rst_n) begin
      if (start && !busy) begin
        power_q = {power_q, power_mod_of(in_base, in_exponent, in_modulus)};
        void'(job_q.pop_front());
        accepted_count++;
        gap_loaded = 1'b0;
      end
      if (start && busy) begin
        send = 1'b1;
      end else if (job_q.size() > 0) begin
        if (!gap_loaded) begin
          gap_left = job_q[0].gap;
          gap_loaded = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
        end else if (!(job_q[0].drain && power_q.size() > 0)) begin
          send = 1'b1;
          in_base <= job_q[0].base;
          in_exponent <= job_q[0].exponent;
          in_modulus <= job_q[0].modulus;
        end
      end
    end
    start <= send;
  end

  always @(posedge clk) begin : monitor
    logic [MOD_W-1:0] want;
    if (rst_n && out_valid) begin
      if (power_q.size() == 0) begin
        report_mismatch($sformatf("result %0d with no word outstanding", out_power_mod));
      end else begin
        want = power_q.pop_front();
        if (out_power_mod !== want) begin
          report_mismatch($sformatf("power_mod got %0d expected %0d", out_power_mod, want));
        end
      end
    end
  end

  initial begin
    logic [63:0]       r64;
    logic [BASE_W-1:0] b;
    logic [EXP_W-1:0]  e;
    logic [MOD_W-1:0]  m;
    int unsigned       gap;
    localparam logic [BASE_W-1:0] BASE_MAX = '1;
    localparam logic [EXP_W-1:0]  EXP_MAX = '1;
    localparam logic [MOD_W-1:0]  MOD_MAX = '1;

    // corner words
    add_job('0, '0, 31'd1, 0, 1'b0);
    add_job('0, '0, 31'd7, 0, 1'b0);
    add_job('0, 32'd5, 31'd7, 3, 1'b0);
    add_job(BASE_MAX, EXP_MAX, MOD_MAX, 0, 1'b0);
    add_job(BASE_MAX, '0, MOD_MAX, 0, 1'b0);
    add_job(BASE_MAX, 32'd1, MOD_MAX, 1, 1'b0);
    add_job(63'd1, EXP_MAX, 31'd2, 0, 1'b0);
    add_job(63'd3, EXP_MAX, 31'd2, 0, 1'b0);
    add_job(63'd4, 32'd9, 31'd2, 0, 1'b0);
    add_job(BASE_MAX, EXP_MAX, 31'd1, 2, 1'b0);
    add_job(63'd12345, 32'd678, '0, 0, 1'b0);
    add_job(BASE_MAX, EXP_MAX, '0, 0, 1'b0);
    add_job(63'd1000003, 32'd3, 31'd1000003, 0, 1'b0);
    add_job(63'(MOD_MAX) - 1, EXP_MAX, MOD_MAX, 0, 1'b1);
    add_job(63'd2, 32'h8000_0000, MOD_MAX, 0, 1'b0);
    add_job(63'd2, 32'h7fff_ffff, 31'h4000_0000, 0, 1'b0);
    add_job(63'h5555_5555_5555_5555, 32'haaaa_aaaa, 31'h2aaa_aaaa, 0, 1'b0);
    add_job(63'h2aaa_aaaa_aaaa_aaaa, 32'h5555_5555, 31'h5555_5555, 4, 1'b0);
    add_job(63'd10, 32'd2, 31'd3, 0, 1'b0);
    add_job(63'h4000_0000_0000_0000, 32'd1, 31'd3, 0, 1'b0);
    add_job(63'd7, 32'd1, 31'd13, 7, 1'b0);

    // random words; bursts with no gaps every 40 words
    for (int n = 0; n < 270; n++) begin
      r64 = {$urandom(), $urandom()};
      case ($urandom_range(3))
        0: b = BASE_W'($urandom_range(16));
        1: b = BASE_MAX - BASE_W'($urandom_range(16));
        default: b = r64[BASE_W-1:0];
      endcase
      case ($urandom_range(4))
        0: e = $urandom_range(16);
        1: e = EXP_MAX - $urandom_range(3);
        default: e = $urandom();
      endcase
      case ($urandom_range(39))
        0: m = '0;
        1, 2, 3: m = MOD_W'($urandom_range(20, 1));
        4, 5: m = MOD_MAX - MOD_W'($urandom_range(8));
        6, 7: m = 31'd1 << $urandom_range(30);
        default: begin
          m = MOD_W'($urandom());
          if (m == '0) begin
            m = 31'd1;
          end
        end
      endcase
      gap = ((n % 40) < 12) ? 0 : $urandom_range(7);
      add_job(b, e, m, gap, $urandom_range(29) == 0);
    end

    while (accepted_count != total_jobs) @(posedge clk);
    while (power_q.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/mexp_pkg.sv
rtl/core/mexp_mulmod.sv
rtl/core/modular_exponentiation_top.sv
rtl/core/mexp_chk.sv
sim/modular_exponentiation_top_test.sv
